[hdl/hill_cipher_2x2_pair_core_defines.svh]
// Assertion helpers for the hill cipher pair core.
`ifndef HILL_CIPHER_2X2_PAIR_CORE_DEFINES_SVH
`define HILL_CIPHER_2X2_PAIR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("hcp assertion failed");

// Next-cycle implication, checked outside reset.
`define HCP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hcp assertion failed");

`endif

[hdl/hcp_pkg.sv]
package hcp_pkg;

  localparam int HCP_QUEUE_DEPTH = 4;

  localparam logic [4:0] PAD_LETTER = 5'd23;
  localparam logic [6:0] LOWER_A    = 7'd97;

  typedef enum logic [2:0] {
    CFG_MODE         = 3'd0,
    CFG_KEY_TL       = 3'd1,
    CFG_KEY_TR       = 3'd2,
    CFG_KEY_BL       = 3'd3,
    CFG_KEY_BR       = 3'd4
  } cfg_idx_t;

  // one unit of work for the back end
  typedef struct packed {
    logic       err;
    logic       last;
    logic [4:0] p0;
    logic [4:0] p1;
  } job_t;

  // active matrix for the current mode
  typedef struct packed {
    logic       busy;
    logic       ok;
    logic [4:0] m00;
    logic [4:0] m01;
    logic [4:0] m10;
    logic [4:0] m11;
  } key_t;

  // x mod 26 for x < 2048: reciprocal estimate, then one correction
  function automatic logic [4:0] mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  qt;
    logic [10:0] r;
    prod = 23'(x) * 23'd2520;
    qt   = prod[22:16];
    r    = x - 11'(qt) * 11'd26;
    if (r >= 11'd26) begin
      r = r - 11'd26;
    end
    return r[4:0];
  endfunction

endpackage

[hdl/hcp_key.sv]
module hcp_key
  import hcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data,
  output key_t       key
);

  localparam logic [2:0] SETTLE_CYCLES = 3'd6;

  logic       mode;
  logic [4:0] k00, k01, k10, k11;
  logic [2:0] settle;

  logic [4:0] a, b, c, d;
  logic [9:0] ad, bc;
  logic [4:0] p, q;
  logic [4:0] inv;
  logic [9:0] pm00, pm01, pm10, pm11;
  logic [4:0] m00, m01, m10, m11;
  logic       ok;

  logic [4:0] det;
  logic [4:0] nb, nc;

  function automatic logic [4:0] red26(input logic [4:0] v);
    return (v >= 5'd26) ? v - 5'd26 : v;
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic logic [4:0] inv26(input logic [4:0] v);
    logic [4:0] r;
    unique case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      k00    <= 5'd1;
      k01    <= 5'd0;
      k10    <= 5'd0;
      k11    <= 5'd1;
      settle <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle <= SETTLE_CYCLES;
        case (cfg_idx_t'(cfg_index))
          CFG_MODE:   mode <= cfg_data[0];
          CFG_KEY_TL: k00  <= cfg_data;
          CFG_KEY_TR: k01  <= cfg_data;
          CFG_KEY_BL: k10  <= cfg_data;
          CFG_KEY_BR: k11  <= cfg_data;
          default: ;
        endcase
      end else if (settle != 3'd0) begin
        settle <= settle - 3'd1;
      end
    end
  end

  always_comb begin
    det = (p >= q) ? p - q : p + 5'd26 - q;
    nb  = (b == 5'd0) ? 5'd0 : 5'd26 - b;
    nc  = (c == 5'd0) ? 5'd0 : 5'd26 - c;
  end

  // derivation pipeline; config must stay put while items are in flight, which the block itself does not enforce
  always_ff @(posedge clk) begin
    a   <= red26(k00);
    b   <= red26(k01);
    c   <= red26(k10);
    d   <= red26(k11);
    ad  <= 10'(a) * 10'(d);
    bc  <= 10'(b) * 10'(c);
    p   <= mod26(11'(ad));
    q   <= mod26(11'(bc));
    inv <= inv26(det);
    if (mode) begin
      pm00 <= 10'(inv) * 10'(d);
      pm01 <= 10'(inv) * 10'(nb);
      pm10 <= 10'(inv) * 10'(nc);
      pm11 <= 10'(inv) * 10'(a);
    end else begin
      pm00 <= 10'(a);
      pm01 <= 10'(b);
      pm10 <= 10'(c);
      pm11 <= 10'(d);
    end
    m00 <= mod26(11'(pm00));
    m01 <= mod26(11'(pm01));
    m10 <= mod26(11'(pm10));
    m11 <= mod26(11'(pm11));
    ok  <= !mode || (inv != 5'd0);
  end

  assign key.busy = (settle != 3'd0);
  assign key.ok   = ok;
  assign key.m00  = m00;
  assign key.m01  = m01;
  assign key.m10  = m10;
  assign key.m11  = m11;

endmodule

[hdl/hcp_front.sv]
module hcp_front
  import hcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_in,
  input  logic       key_busy,
  input  logic       key_ok,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic       holding;
  logic [4:0] held_letter;
  logic       message_bad;

  logic       accept;
  logic       is_upper, is_lower, bad;
  logic [4:0] value;

  always_comb begin
    is_upper = (char_in >= 8'd65) && (char_in <= 8'd90);
    is_lower = (char_in >= 8'd97) && (char_in <= 8'd122);
    value    = is_upper ? 5'(char_in - 8'd65) : 5'(char_in - 8'd97);
    bad      = message_bad || !(is_upper || is_lower) || !key_ok;
    in_ready = !key_busy && !q_full;
    accept   = in_valid && in_ready;
    push     = accept && (bad || holding || last_in);
    push_job.err  = bad;
    push_job.last = last_in;
    push_job.p0   = holding ? held_letter : value;
    push_job.p1   = holding ? value : PAD_LETTER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding     <= 1'b0;
      held_letter <= 5'd0;
      message_bad <= 1'b0;
    end else if (accept) begin
      if (bad) begin
        message_bad <= !last_in;
        holding     <= 1'b0;
      end else if (!holding && !last_in) begin
        held_letter <= value;
        holding     <= 1'b1;
      end else begin
        holding <= 1'b0;
      end
    end
  end

endmodule

[hdl/hcp_queue.sv]
module hcp_queue
  import hcp_pkg::*;
#(
  parameter int DEPTH = HCP_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CW'(DEPTH));
  assign q_job   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hdl/hcp_back.sv]
module hcp_back
  import hcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  key_t       key,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] letter_out,
  output logic       error_out,
  output logic       last_out
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_OUT1, S_OUT2} state_t;

  state_t      state;
  logic        job_err, job_last;
  logic [10:0] sum0, sum1;
  logic [4:0]  res1;

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            job_err  <= q_job.err;
            job_last <= q_job.last;
            sum0     <= 11'(key.m00) * 11'(q_job.p0) + 11'(key.m01) * 11'(q_job.p1);
            sum1     <= 11'(key.m10) * 11'(q_job.p0) + 11'(key.m11) * 11'(q_job.p1);
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          out_valid <= 1'b1;
          if (job_err) begin
            letter_out <= 7'd0;
            error_out  <= 1'b1;
            last_out   <= job_last;
          end else begin
            letter_out <= LOWER_A + 7'(mod26(sum0));
            error_out  <= 1'b0;
            last_out   <= 1'b0;
          end
          res1  <= mod26(sum1);
          state <= S_OUT1;
        end
        S_OUT1: begin
          if (out_ready) begin
            if (job_err) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              letter_out <= LOWER_A + 7'(res1);
              last_out   <= job_last;
              state      <= S_OUT2;
            end
          end
        end
        S_OUT2: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[hdl/hill_cipher_2x2_pair_core.sv]
// 2x2 Hill cipher over a character stream.
// Input stream s_axis: one ASCII character per word, tlast on the final
// character of a message. Letters of either case are taken; anything else
// turns the rest of the message into error words.
// Output stream m_axis: lowercase letters, two per letter pair; an odd final
// letter is padded with 'x'. tuser flags error words (data zero), tlast
// marks the final word of the message.
// Config port: cfg_we/cfg_index/cfg_data write mode and the four key
// entries; write only while idle. A write blocks input while the active
// matrix (inverse key in decrypt mode) is rederived.
// A completing character pushes a job; the back end pops it when idle,
// computes in its calc step and presents the words in its two output steps
// (one for an error word), popping no new job until done. The front takes
// one character per cycle while the queue has room and the key is not busy.
// Reset clears message state, loads the identity key in encrypt mode and
// holds s_axis_tready low while the key is rederived. A stalled receiver
// holds the output word; the queue then fills and s_axis_tready drops.
module hill_cipher_2x2_pair_core
  import hcp_pkg::*;
#(
  parameter int QUEUE_DEPTH = HCP_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] letter_out, [7] zero
  output logic       m_axis_tuser,   // [0] error_out
  output logic       m_axis_tlast
);

  `include "hill_cipher_2x2_pair_core_defines.svh"

  key_t       key;
  logic       push, pop, q_valid, q_full;
  job_t       push_job, q_job;
  logic [6:0] letter;

  hcp_key u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  hcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .char_in  (s_axis_tdata),
    .last_in  (s_axis_tlast),
    .key_busy (key.busy),
    .key_ok   (key.ok),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  hcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  hcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .letter_out (letter),
    .error_out  (m_axis_tuser),
    .last_out   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, letter};

  `HCP_ASSERT_NOW(a_err_word_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'd0)
  `HCP_ASSERT_NOW(a_letter_range, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata >= 8'd97) && (m_axis_tdata <= 8'd122))
  `HCP_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !s_axis_tready)

endmodule
